// File: design/i2cee_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the I2C EEPROM byte access master.
// No dependencies; imported by every module of the block.
package i2cee_pkg;

	// Command codes of an input transaction
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DEVICE_ADDRESS    = 2'd0,
		REG_TICKS_PER_PHASE   = 2'd1,
		REG_ACK_TIMEOUT       = 2'd2,
		REG_WRITE_CYCLE_TICKS = 2'd3
	} cfg_index_t;

	localparam int CFG_DATA_W = 24;

	localparam logic [6:0]  DEVICE_ADDRESS_RST    = 7'd80;
	localparam logic [15:0] TICKS_PER_PHASE_RST   = 16'd1;
	localparam logic [7:0]  ACK_TIMEOUT_RST       = 8'd200;
	localparam logic [23:0] WRITE_CYCLE_TICKS_RST = 24'd10000;

	// Which byte of the transfer is on the bus
	localparam logic [1:0] BS_DEVICE  = 2'd0;
	localparam logic [1:0] BS_ADDRESS = 2'd1;
	localparam logic [1:0] BS_PAYLOAD = 2'd2;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [19:0] {
		ST_IDLE = 20'h00001,
		ST_ST_A = 20'h00002,
		ST_ST_B = 20'h00004,
		ST_ST_C = 20'h00008,
		ST_TX_A = 20'h00010,
		ST_TX_B = 20'h00020,
		ST_TX_C = 20'h00040,
		ST_AK_A = 20'h00080,
		ST_AK_B = 20'h00100,
		ST_AK_C = 20'h00200,
		ST_RS_A = 20'h00400,
		ST_RX_A = 20'h00800,
		ST_RX_B = 20'h01000,
		ST_NK_A = 20'h02000,
		ST_NK_B = 20'h04000,
		ST_NK_C = 20'h08000,
		ST_SP_A = 20'h10000,
		ST_SP_B = 20'h20000,
		ST_SP_C = 20'h40000,
		ST_WAIT = 20'h80000
	} step_t;

	typedef struct packed {
		logic [6:0]  device_address;
		logic [15:0] ticks_per_phase;
		logic [7:0]  ack_timeout;
		logic [23:0] write_cycle_ticks;
	} cfg_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_result;
		logic       ack_missing;
	} result_t;

endpackage

// File: design/i2c_eeprom_byte_access_master_core.sv
`timescale 1ns / 1ps
// I2C EEPROM byte access master, top level: input register, sequencer, result register.
// Depends on i2cee_pkg, i2cee_cfg and i2cee_seq.
// The result register loads when the sequencer advances the stage-1 transaction.
// Throughput: one transaction and one sequencer tick per cycle unless output stalls.
// Reset (arst_n low, asynchronous): sequencer to idle, counters and flags cleared,
// configuration registers to their defaults, both pipeline stages empty.
module i2c_eeprom_byte_access_master_core #(
	parameter int WORD_ADDRESS_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [i2cee_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     command,
	input  logic [WORD_ADDRESS_BITS-1:0]   word_address,
	input  logic [7:0]                     write_data,
	input  logic                           sda_sample,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           scl_level,
	output logic                           sda_level,
	output logic                           busy_res,
	output logic                           done_res,
	output logic [7:0]                     read_result,
	output logic                           ack_missing
);
	import i2cee_pkg::*;

	cfg_t    cfg;
	result_t result;

	// Stage 1: captured input transaction
	logic                         valid_s1;
	logic [1:0]                   command_s1;
	logic [WORD_ADDRESS_BITS-1:0] word_address_s1;
	logic [7:0]                   write_data_s1;
	logic                         sda_sample_s1;

	// Stage 2: result register facing the output channel
	logic    valid_s2;
	result_t result_s2;

	logic advance;

	// Move the stage-1 transaction through the sequencer whenever the result
	// register is empty or being drained this cycle.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	// Stage 1 takes a new transaction when empty or when it hands its own on.
	assign in_stall = valid_s1 && !advance;

	i2cee_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2cee_seq #(
		.WORD_ADDRESS_BITS (WORD_ADDRESS_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.command      (command_s1),
		.word_address (word_address_s1),
		.write_data   (write_data_s1),
		.sda_sample   (sda_sample_s1),
		.cfg          (cfg),
		.result       (result)
	);

	// Input register: valid bit under reset, payload loads only with a new transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			command_s1      <= command;
			word_address_s1 <= word_address;
			write_data_s1   <= write_data;
			sda_sample_s1   <= sda_sample;
		end
	end

	// Result register: fill on advance, drop once the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign scl_level   = result_s2.scl_level;
	assign sda_level   = result_s2.sda_level;
	assign busy_res    = result_s2.busy_res;
	assign done_res    = result_s2.done_res;
	assign read_result = result_s2.read_result;
	assign ack_missing = result_s2.ack_missing;

endmodule

// File: design/i2cee_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the I2C EEPROM byte access master.
// Depends on i2cee_pkg.
module i2cee_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [i2cee_pkg::CFG_DATA_W-1:0] cfg_data,
	output i2cee_pkg::cfg_t                cfg
);
	import i2cee_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address    <= DEVICE_ADDRESS_RST;
			cfg_q.ticks_per_phase   <= TICKS_PER_PHASE_RST;
			cfg_q.ack_timeout       <= ACK_TIMEOUT_RST;
			cfg_q.write_cycle_ticks <= WRITE_CYCLE_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				REG_DEVICE_ADDRESS:    cfg_q.device_address    <= cfg_data[6:0];
				REG_TICKS_PER_PHASE:   cfg_q.ticks_per_phase   <= cfg_data[15:0];
				REG_ACK_TIMEOUT:       cfg_q.ack_timeout       <= cfg_data[7:0];
				REG_WRITE_CYCLE_TICKS: cfg_q.write_cycle_ticks <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/i2cee_seq.sv
`timescale 1ns / 1ps
// Bus phase sequencer: holds the transfer state and advances it by one tick.
// Depends on i2cee_pkg.
module i2cee_seq #(
	parameter int WORD_ADDRESS_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [1:0]                   command,
	input  logic [WORD_ADDRESS_BITS-1:0] word_address,
	input  logic [7:0]                   write_data,
	input  logic                         sda_sample,
	input  i2cee_pkg::cfg_t              cfg,
	output i2cee_pkg::result_t           result
);
	import i2cee_pkg::*;

	step_t                        step_q, step_nxt;
	logic [3:0]                   bit_q, bit_nxt, bit_inc;
	logic [7:0]                   shift_q, shift_nxt;
	logic [15:0]                  phase_q, phase_nxt;
	logic [7:0]                   ack_q, ack_nxt, ack_sat;
	logic [23:0]                  cycle_q, cycle_nxt, cycle_sat;
	logic                         is_read_q, is_read_nxt;
	logic [WORD_ADDRESS_BITS-1:0] addr_q, addr_nxt;
	logic [7:0]                   data_q, data_nxt;
	logic                         nack_q, nack_nxt;
	logic [1:0]                   stage_q, stage_nxt;
	logic [7:0]                   rbyte_q, rbyte_nxt;
	logic                         phase_end;
	logic                         done;
	logic                         scl, sda;

	assign phase_end = ({1'b0, phase_q} + 17'd1) >= {1'b0, cfg.ticks_per_phase};
	assign bit_inc   = bit_q + 4'd1;
	assign ack_sat   = (ack_q != 8'hFF) ? ack_q + 8'd1 : ack_q;
	assign cycle_sat = (cycle_q != 24'hFFFFFF) ? cycle_q + 24'd1 : cycle_q;

	always_comb begin
		step_nxt    = step_q;
		bit_nxt     = bit_q;
		shift_nxt   = shift_q;
		phase_nxt   = phase_q;
		ack_nxt     = ack_q;
		cycle_nxt   = cycle_q;
		is_read_nxt = is_read_q;
		addr_nxt    = addr_q;
		data_nxt    = data_q;
		nack_nxt    = nack_q;
		stage_nxt   = stage_q;
		rbyte_nxt   = rbyte_q;
		done        = 1'b0;

		unique case (step_q) inside
			ST_IDLE: begin
				if (command == CMD_WRITE || command == CMD_READ) begin
					addr_nxt = word_address;
					if (command == CMD_WRITE)
						data_nxt = write_data;
					is_read_nxt = (command == CMD_READ);
					nack_nxt    = 1'b0;
					stage_nxt   = BS_DEVICE;
					shift_nxt   = {cfg.device_address, 1'b0};
					bit_nxt     = '0;
					step_nxt    = ST_ST_A;
					phase_nxt   = '0;
				end
			end
			ST_AK_B: begin
				if (!phase_end) begin
					phase_nxt = phase_q + 16'd1;
				end else if (!sda_sample) begin
					step_nxt  = ST_AK_C;
					phase_nxt = '0;
				end else begin
					ack_nxt = ack_sat;
					// ACK timed out: flag it and release the bus
					if (ack_sat >= cfg.ack_timeout) begin
						nack_nxt  = 1'b1;
						step_nxt  = ST_SP_A;
						phase_nxt = '0;
					end
				end
			end
			ST_WAIT: begin
				cycle_nxt = cycle_sat;
				if (cycle_sat >= cfg.write_cycle_ticks) begin
					step_nxt  = ST_IDLE;
					phase_nxt = '0;
					done      = 1'b1;
				end
			end
			ST_ST_A, ST_ST_B, ST_ST_C, ST_TX_A, ST_TX_B, ST_TX_C, ST_AK_A, ST_AK_C,
			ST_RS_A, ST_RX_A, ST_RX_B, ST_NK_A, ST_NK_B, ST_NK_C, ST_SP_A, ST_SP_B,
			ST_SP_C: begin
				if (!phase_end) begin
					phase_nxt = phase_q + 16'd1;
				end else begin
					phase_nxt = '0;
					unique case (step_q) inside
						ST_ST_A: step_nxt = ST_ST_B;
						ST_ST_B: step_nxt = ST_ST_C;
						ST_ST_C: begin
							bit_nxt  = '0;
							step_nxt = ST_TX_A;
						end
						ST_TX_A: step_nxt = ST_TX_B;
						ST_TX_B: step_nxt = ST_TX_C;
						ST_TX_C: begin
							shift_nxt = {shift_q[6:0], 1'b0};
							bit_nxt   = bit_inc;
							if (bit_inc >= BITS_PER_BYTE) begin
								ack_nxt  = '0;
								step_nxt = ST_AK_A;
							end else begin
								step_nxt = ST_TX_A;
							end
						end
						ST_AK_A: step_nxt = ST_AK_B;
						ST_AK_C: begin
							if (stage_q == BS_DEVICE) begin
								stage_nxt = BS_ADDRESS;
								shift_nxt = 8'(addr_q);
								bit_nxt   = '0;
								step_nxt  = ST_TX_A;
							end else if (stage_q == BS_ADDRESS) begin
								stage_nxt = BS_PAYLOAD;
								if (is_read_q) begin
									shift_nxt = {cfg.device_address, 1'b1};
									step_nxt  = ST_RS_A;
								end else begin
									shift_nxt = data_q;
									bit_nxt   = '0;
									step_nxt  = ST_TX_A;
								end
							end else if (is_read_q) begin
								shift_nxt = '0;
								bit_nxt   = '0;
								step_nxt  = ST_RX_A;
							end else begin
								step_nxt = ST_SP_A;
							end
						end
						ST_RS_A: step_nxt = ST_ST_A;
						ST_RX_A: step_nxt = ST_RX_B;
						ST_RX_B: begin
							shift_nxt = {shift_q[6:0], sda_sample};
							bit_nxt   = bit_inc;
							if (bit_inc >= BITS_PER_BYTE) begin
								rbyte_nxt = {shift_q[6:0], sda_sample};
								step_nxt  = ST_NK_A;
							end else begin
								step_nxt = ST_RX_A;
							end
						end
						ST_NK_A: step_nxt = ST_NK_B;
						ST_NK_B: step_nxt = ST_NK_C;
						ST_NK_C: step_nxt = ST_SP_A;
						ST_SP_A: step_nxt = ST_SP_B;
						ST_SP_B: step_nxt = ST_SP_C;
						ST_SP_C: begin
							if (nack_q || is_read_q || cfg.write_cycle_ticks == 24'd0) begin
								step_nxt = ST_IDLE;
								done     = 1'b1;
							end else begin
								cycle_nxt = '0;
								step_nxt  = ST_WAIT;
							end
						end
						default: step_nxt = ST_IDLE;
					endcase
				end
			end
			default: begin
				step_nxt  = ST_IDLE;
				phase_nxt = '0;
			end
		endcase
	end

	// Line drive follows the step just entered
	always_comb begin
		unique case (step_nxt) inside
			ST_ST_B:                 begin scl = 1'b1; sda = 1'b0;         end
			ST_ST_C:                 begin scl = 1'b0; sda = 1'b0;         end
			ST_TX_A, ST_TX_C:        begin scl = 1'b0; sda = shift_nxt[7]; end
			ST_TX_B:                 begin scl = 1'b1; sda = shift_nxt[7]; end
			ST_AK_A, ST_AK_C, ST_RS_A, ST_RX_A, ST_NK_A, ST_NK_C:
			                         begin scl = 1'b0; sda = 1'b1;         end
			ST_SP_A:                 begin scl = 1'b0; sda = 1'b0;         end
			ST_SP_B:                 begin scl = 1'b1; sda = 1'b0;         end
			default:                 begin scl = 1'b1; sda = 1'b1;         end
		endcase
	end

	always_comb begin
		result.scl_level   = scl;
		result.sda_level   = sda;
		result.busy_res    = (step_nxt != ST_IDLE);
		result.done_res    = done;
		result.read_result = rbyte_nxt;
		result.ack_missing = nack_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= ST_IDLE;
			bit_q     <= '0;
			shift_q   <= '0;
			phase_q   <= '0;
			ack_q     <= '0;
			cycle_q   <= '0;
			is_read_q <= 1'b0;
			addr_q    <= '0;
			data_q    <= '0;
			nack_q    <= 1'b0;
			stage_q   <= BS_DEVICE;
			rbyte_q   <= '0;
		end else if (advance) begin
			step_q    <= step_nxt;
			bit_q     <= bit_nxt;
			shift_q   <= shift_nxt;
			phase_q   <= phase_nxt;
			ack_q     <= ack_nxt;
			cycle_q   <= cycle_nxt;
			is_read_q <= is_read_nxt;
			addr_q    <= addr_nxt;
			data_q    <= data_nxt;
			nack_q    <= nack_nxt;
			stage_q   <= stage_nxt;
			rbyte_q   <= rbyte_nxt;
		end
	end

endmodule

// File: tb/i2c_eeprom_byte_access_master_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the I2C EEPROM byte access master core.
// Needs i2cee_pkg and the core; predicts every result of the tick sequencer and compares it.
module i2c_eeprom_byte_access_master_core_tb;
	import i2cee_pkg::*;

	// Command 3 is unused by the block and behaves like a tick
	localparam logic [1:0] CMD_SPARE = 2'd3;

	localparam int unsigned RANDOM_TICKS   = 100;
	localparam int unsigned HOLD_CYCLES    = 64;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  command = CMD_TICK;
	logic [7:0]  word_address = '0;
	logic [7:0]  write_data = '0;
	logic        sda_sample = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        scl_level;
	logic        sda_level;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_result;
	logic        ack_missing;

	i2c_eeprom_byte_access_master_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.word_address (word_address),
		.write_data   (write_data),
		.sda_sample   (sda_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scl_level    (scl_level),
		.sda_level    (sda_level),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.read_result  (read_result),
		.ack_missing  (ack_missing)
	);

	always #5 clk = ~clk;

	// Bus states predicted for accepted transactions, oldest first
	result_t     bus_state_q[$];
	int unsigned fail_count = 0;
	int unsigned ticks_sent = 0;

	// Traffic shaping, shared by the sender and the receiver
	bit          quiet = 1'b0;          // no random idling on either side
	int unsigned hold_req_cnt = 0;      // bump to make the receiver hold off
	int unsigned hold_seen_cnt = 0;
	int unsigned hold_left = 0;

	// ACK responder: which acknowledge slots of the current bus transfer get denied
	int          deny_pct = 0;
	int          deny_slot = -1;
	int          ack_slot_no = 0;
	int          ack_slip_pct = 0;      // high samples sprinkled before a granted ACK
	bit          in_ack_slot = 1'b0;
	bit          deny_ack = 1'b0;

	// Sequencer mirror: configuration and state
	cfg_t        m_cfg;
	step_t       m_step;
	logic [3:0]  m_bits;
	logic [7:0]  m_shift;
	logic [15:0] m_phase;
	logic [7:0]  m_ack_wait;
	logic [23:0] m_cycle_wait;
	logic        m_is_read;
	logic [7:0]  m_addr;
	logic [7:0]  m_data;
	logic        m_nack;
	logic [1:0]  m_stage;
	logic [7:0]  m_read_byte;

	function automatic void reset_sequencer_mirror();
		m_cfg.device_address    = DEVICE_ADDRESS_RST;
		m_cfg.ticks_per_phase   = TICKS_PER_PHASE_RST;
		m_cfg.ack_timeout       = ACK_TIMEOUT_RST;
		m_cfg.write_cycle_ticks = WRITE_CYCLE_TICKS_RST;
		m_step       = ST_IDLE;
		m_bits       = '0;
		m_shift      = '0;
		m_phase      = '0;
		m_ack_wait   = '0;
		m_cycle_wait = '0;
		m_is_read    = 1'b0;
		m_addr       = '0;
		m_data       = '0;
		m_nack       = 1'b0;
		m_stage      = BS_DEVICE;
		m_read_byte  = '0;
	endfunction

	function automatic void enter_step(step_t s);
		m_step  = s;
		m_phase = '0;
	endfunction

	function automatic void load_byte(logic [7:0] value);
		m_shift = value;
		m_bits  = '0;
		enter_step(ST_TX_A);
	endfunction

	// Advance the mirror by one tick and return the bus state the block must show
	function automatic result_t predict_bus_tick(logic [1:0] cmd, logic [7:0] addr,
			logic [7:0] data, logic sda);
		result_t r;
		logic    phase_end;
		logic    done;
		phase_end = (int'(m_phase) + 1) >= int'(m_cfg.ticks_per_phase);
		done = 1'b0;
		case (m_step)
			ST_IDLE: begin
				// requests only start from idle
				if (cmd == CMD_WRITE || cmd == CMD_READ) begin
					m_addr = addr;
					if (cmd == CMD_WRITE)
						m_data = data;
					m_is_read = (cmd == CMD_READ);
					m_nack    = 1'b0;
					m_stage   = BS_DEVICE;
					m_shift   = {m_cfg.device_address, 1'b0};
					m_bits    = '0;
					enter_step(ST_ST_A);
				end
			end
			ST_AK_B: begin
				if (!phase_end) begin
					m_phase++;
				end else if (sda == 1'b0) begin
					enter_step(ST_AK_C);
				end else begin
					if (m_ack_wait < 8'd255)
						m_ack_wait++;
					if (m_ack_wait >= m_cfg.ack_timeout) begin
						m_nack = 1'b1;
						enter_step(ST_SP_A);
					end
				end
			end
			ST_WAIT: begin
				if (m_cycle_wait < 24'hFFFFFF)
					m_cycle_wait++;
				if (m_cycle_wait >= m_cfg.write_cycle_ticks) begin
					enter_step(ST_IDLE);
					done = 1'b1;
				end
			end
			default: begin
				if (!phase_end) begin
					m_phase++;
				end else begin
					case (m_step)
						ST_ST_A: enter_step(ST_ST_B);
						ST_ST_B: enter_step(ST_ST_C);
						ST_ST_C: load_byte(m_shift);
						ST_TX_A: enter_step(ST_TX_B);
						ST_TX_B: enter_step(ST_TX_C);
						ST_TX_C: begin
							m_shift = m_shift << 1;
							m_bits  = m_bits + 4'd1;
							if (m_bits >= BITS_PER_BYTE) begin
								m_ack_wait = '0;
								enter_step(ST_AK_A);
							end else begin
								enter_step(ST_TX_A);
							end
						end
						ST_AK_A: enter_step(ST_AK_B);
						ST_AK_C: begin
							if (m_stage == BS_DEVICE) begin
								m_stage = BS_ADDRESS;
								load_byte(m_addr);
							end else if (m_stage == BS_ADDRESS) begin
								m_stage = BS_PAYLOAD;
								if (m_is_read) begin
									m_shift = {m_cfg.device_address, 1'b1};
									enter_step(ST_RS_A);
								end else begin
									load_byte(m_data);
								end
							end else if (m_is_read) begin
								m_shift = '0;
								m_bits  = '0;
								enter_step(ST_RX_A);
							end else begin
								enter_step(ST_SP_A);
							end
						end
						ST_RS_A: enter_step(ST_ST_A);
						ST_RX_A: enter_step(ST_RX_B);
						ST_RX_B: begin
							// data bit is taken as the SCL-high phase ends, MSB first
							m_shift = {m_shift[6:0], sda};
							m_bits  = m_bits + 4'd1;
							if (m_bits >= BITS_PER_BYTE) begin
								m_read_byte = m_shift;
								enter_step(ST_NK_A);
							end else begin
								enter_step(ST_RX_A);
							end
						end
						ST_NK_A: enter_step(ST_NK_B);
						ST_NK_B: enter_step(ST_NK_C);
						ST_NK_C: enter_step(ST_SP_A);
						ST_SP_A: enter_step(ST_SP_B);
						ST_SP_B: enter_step(ST_SP_C);
						ST_SP_C: begin
							// skip the write cycle wait after a timeout, a read or a zero length
							if (m_nack || m_is_read || m_cfg.write_cycle_ticks == 24'd0) begin
								enter_step(ST_IDLE);
								done = 1'b1;
							end else begin
								m_cycle_wait = '0;
								enter_step(ST_WAIT);
							end
						end
						default: enter_step(ST_IDLE);
					endcase
				end
			end
		endcase

		case (m_step)
			ST_ST_B:                   begin r.scl_level = 1'b1; r.sda_level = 1'b0; end
			ST_ST_C:                   begin r.scl_level = 1'b0; r.sda_level = 1'b0; end
			ST_TX_A, ST_TX_C:          begin r.scl_level = 1'b0; r.sda_level = m_shift[7]; end
			ST_TX_B:                   begin r.scl_level = 1'b1; r.sda_level = m_shift[7]; end
			ST_AK_A, ST_AK_C, ST_RS_A, ST_RX_A, ST_NK_A, ST_NK_C: begin
				r.scl_level = 1'b0;
				r.sda_level = 1'b1;
			end
			ST_SP_A:                   begin r.scl_level = 1'b0; r.sda_level = 1'b0; end
			ST_SP_B:                   begin r.scl_level = 1'b1; r.sda_level = 1'b0; end
			default:                   begin r.scl_level = 1'b1; r.sda_level = 1'b1; end
		endcase
		r.busy_res    = (m_step != ST_IDLE);
		r.done_res    = done;
		r.read_result = m_read_byte;
		r.ack_missing = m_nack;
		return r;
	endfunction

	// Offer one input transaction and predict its result once it is accepted.
	// Valid stays high on return so a back-to-back transaction need not raise it again.
	task automatic send_item(logic [1:0] cmd, logic [7:0] addr, logic [7:0] data, logic sda);
		while (!quiet && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		word_address <= addr;
		write_data   <= data;
		sda_sample   <= sda;
		@(posedge clk);
		// hold the payload until the block stops stalling
		while (in_stall)
			@(posedge clk);
		bus_state_q.push_back(predict_bus_tick(cmd, addr, data, sda));
		ticks_sent++;
	endtask

	// One tick with random noise in the unused fields. Requests while busy must be ignored;
	// during an acknowledge slot play the slave: grant or withhold the ACK.
	task automatic send_tick();
		logic [1:0]  cmd;
		logic        sda;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		cmd = (pick < 7) ? CMD_TICK : (pick == 7) ? CMD_SPARE : (pick == 8) ? CMD_WRITE : CMD_READ;
		if (m_step == ST_IDLE && (cmd == CMD_WRITE || cmd == CMD_READ))
			cmd = CMD_TICK;
		if (m_step == ST_AK_B) begin
			if (!in_ack_slot) begin
				in_ack_slot = 1'b1;
				deny_ack = (ack_slot_no == deny_slot) || ($urandom_range(0, 99) < deny_pct);
				ack_slot_no++;
			end
			sda = deny_ack ? 1'b1 : ($urandom_range(0, 99) < ack_slip_pct);
		end else begin
			in_ack_slot = 1'b0;
			sda = 1'($urandom_range(0, 1));
		end
		send_item(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sda);
	endtask

	task automatic start_transfer(logic [1:0] cmd, logic [7:0] addr, logic [7:0] data,
			int pct, int slot);
		deny_pct    = pct;
		deny_slot   = slot;
		ack_slot_no = 0;
		send_item(cmd, addr, data, 1'($urandom_range(0, 1)));
	endtask

	// Tick until the sequencer is back in idle
	task automatic finish_transfer();
		while (m_step != ST_IDLE)
			send_tick();
	endtask

	task automatic run_transfer(logic [1:0] cmd, logic [7:0] addr, logic [7:0] data,
			int pct, int slot);
		start_transfer(cmd, addr, data, pct, slot);
		finish_transfer();
	endtask

	// Drop valid and wait until every predicted result has been taken
	task automatic drain();
		in_valid <= 1'b0;
		while (bus_state_q.size() != 0)
			@(posedge clk);
	endtask

	// Write all four registers on an empty pipeline; raw data may carry junk above each width
	task automatic configure(logic [23:0] dev, logic [23:0] tpp, logic [23:0] ato,
			logic [23:0] wct);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_DEVICE_ADDRESS;
		cfg_data  <= dev;
		@(posedge clk);
		cfg_index <= REG_TICKS_PER_PHASE;
		cfg_data  <= tpp;
		@(posedge clk);
		cfg_index <= REG_ACK_TIMEOUT;
		cfg_data  <= ato;
		@(posedge clk);
		cfg_index <= REG_WRITE_CYCLE_TICKS;
		cfg_data  <= wct;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_cfg.device_address    = dev[6:0];
		m_cfg.ticks_per_phase   = tpp[15:0];
		m_cfg.ack_timeout       = ato[7:0];
		m_cfg.write_cycle_ticks = wct;
	endtask

	// Reset defaults: the spare command, an idle tick, then a read with the default setup
	task automatic test_default_read();
		repeat (3)
			send_item(CMD_SPARE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
		send_item(CMD_TICK, 8'hFF, 8'hFF, 1'b0);
		run_transfer(CMD_READ, 8'hFF, 8'h00, 0, -1);
	endtask

	// Address and data extremes, zero phase length, zero write cycle
	task automatic test_field_extremes();
		configure({17'h1FFFF, 7'd127}, 24'h000000, 24'd200, 24'd0);
		run_transfer(CMD_WRITE, 8'h00, 8'hFF, 0, -1);
		run_transfer(CMD_READ, 8'hFF, 8'h00, 0, -1);
		configure(24'd0, 24'd2, 24'hFFFF00 | 24'd255, 24'd5);
		run_transfer(CMD_WRITE, 8'hA5, 8'h5A, 0, -1);
		run_transfer(CMD_READ, 8'h5A, 8'hA5, 0, -1);
	endtask

	// Missing ACK on each byte: stop follows, flag sets, read data is kept
	task automatic test_ack_timeout();
		configure(24'd80, 24'd1, 24'd1, 24'd3);
		run_transfer(CMD_WRITE, 8'h12, 8'h34, 0, 0);
		run_transfer(CMD_WRITE, 8'h56, 8'h78, 0, 2);
		run_transfer(CMD_READ, 8'h9A, 8'h00, 0, 2);
		configure(24'd80, 24'd1, 24'd255, 24'd3);
		run_transfer(CMD_WRITE, 8'hBC, 8'hDE, 0, 1);
		// a zero timeout acts like one
		configure(24'd80, 24'd1, 24'd0, 24'd3);
		run_transfer(CMD_READ, 8'h01, 8'h00, 0, 0);
	endtask

	// Longest write cycle and phase settings, reached without waiting them out
	task automatic test_long_settings();
		int unsigned n;
		configure(24'd80, 24'd1, 24'd8, 24'hFFFFFF);
		run_transfer(CMD_READ, 8'h3C, 8'h00, 0, -1);
		run_transfer(CMD_WRITE, 8'hC3, 8'h99, 0, 0);
		configure(24'd80, 24'hFFFF, 24'd8, 24'hFFFFFF);
		start_transfer(CMD_WRITE, 8'h77, 8'h88, 0, -1);
		for (n = 0; n < 40; n++)
			send_tick();
		// shrink the phase mid-transfer so the stretched phase ends at once
		configure(24'd80, 24'd1, 24'd8, 24'd2);
		finish_transfer();
	endtask

	// No idling at all, with one long receiver hold-off that backs up the block
	task automatic test_backpressure();
		quiet = 1'b1;
		hold_req_cnt++;
		run_transfer(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, -1);
		run_transfer(CMD_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, -1);
		quiet = 1'b0;
	endtask

	// Random bus transfers under random settings, with noise ticks in idle and while busy
	task automatic test_random_traffic();
		int unsigned goal;
		int unsigned pick;
		logic [23:0] tpp;
		logic [23:0] ato;
		goal = ticks_sent + RANDOM_TICKS;
		ack_slip_pct = 25;
		while (ticks_sent < goal) begin
			if ($urandom_range(0, 3) == 0) begin
				pick = $urandom_range(0, 9);
				tpp = (pick < 6) ? 24'd1 : (pick < 9) ? 24'($urandom_range(2, 3)) :
					24'($urandom_range(4, 6));
				ato = ($urandom_range(0, 5) == 0) ? 24'd255 : 24'($urandom_range(1, 8));
				configure({17'($urandom_range(0, 17'h1FFFF)), 7'($urandom_range(0, 127))}, tpp,
					{16'($urandom_range(0, 16'hFFFF)), ato[7:0]}, 24'($urandom_range(0, 40)));
			end
			repeat ($urandom_range(0, 3))
				send_tick();
			run_transfer($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 10, -1);
		end
		ack_slip_pct = 0;
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req_cnt != hold_seen_cnt) begin
			out_stall     <= 1'b1;
			hold_seen_cnt <= hold_req_cnt;
			hold_left     <= HOLD_CYCLES;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 20);
		end
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Compare each accepted result against the oldest prediction
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (bus_state_q.size() == 0) begin
				$error("result transaction with no prediction pending");
				fail_count++;
			end else begin
				want = bus_state_q.pop_front();
				check_field("scl_level", want.scl_level, scl_level);
				check_field("sda_level", want.sda_level, sda_level);
				check_field("busy_res", want.busy_res, busy_res);
				check_field("done_res", want.done_res, done_res);
				check_field("read_result", want.read_result, read_result);
				check_field("ack_missing", want.ack_missing, ack_missing);
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long
	initial begin : watchdog
		int unsigned stuck_cycles;
		stuck_cycles = 0;
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("i2c_eeprom_byte_access_master_core_tb failed");
		$finish;
	end

	initial begin
		reset_sequencer_mirror();
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_read();
		test_field_extremes();
		test_ack_timeout();
		test_long_settings();
		test_backpressure();
		test_random_traffic();

		// let the last results come out, then give the input and result registers time to empty
		drain();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (bus_state_q.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("i2c_eeprom_byte_access_master_core_tb passed");
		else
			$display("i2c_eeprom_byte_access_master_core_tb failed");
		$finish;
	end

endmodule

// File: files.f
design/i2cee_pkg.sv
design/i2cee_cfg.sv
design/i2cee_seq.sv
design/i2c_eeprom_byte_access_master_core.sv
tb/i2c_eeprom_byte_access_master_core_tb.sv
